// ===== design/b32kd_pkg.sv =====
package b32kd_pkg;

   // status codes, sticky per string
   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_BAD_CHAR = 2'd1;
   localparam logic [1:0] STATUS_BAD_PAD  = 2'd2;
   localparam logic [1:0] STATUS_BAD_LEN  = 2'd3;

   localparam logic [7:0] PAD_CHAR  = 8'h3D;
   localparam logic [2:0] PAD_LIMIT = 3'd6;
   localparam logic [2:0] PAD_MAX   = 3'd7;

   typedef struct packed {
      logic [7:0] in_char;
      logic       last;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       done_res;
      logic [1:0] status;
   } rsp_type;

endpackage

// ===== design/b32kd_sym.sv =====
// base32 alphabet lookup with the aliases 0, 1 and 8
module b32kd_sym import b32kd_pkg::*; (
   input  logic [7:0] in_char,
   output logic [4:0] sym_value,
   output logic       sym_ok
);

   logic [7:0] upper_off;
   logic [7:0] lower_off;
   logic [7:0] digit_off;

   assign upper_off = in_char - 8'h41;
   assign lower_off = in_char - 8'h61;
   assign digit_off = in_char - 8'h32 + 8'd26;

   always_comb begin
      sym_value = 5'd0;
      sym_ok    = 1'b1;
      if (in_char >= 8'h41 && in_char <= 8'h5A) begin
         sym_value = upper_off[4:0];
      end else if (in_char >= 8'h61 && in_char <= 8'h7A) begin
         sym_value = lower_off[4:0];
      end else if (in_char >= 8'h32 && in_char <= 8'h37) begin
         sym_value = digit_off[4:0];
      end else if (in_char == 8'h30) begin
         sym_value = 5'd14;
      end else if (in_char == 8'h31) begin
         sym_value = 5'd11;
      end else if (in_char == 8'h38) begin
         sym_value = 5'd1;
      end else begin
         sym_ok = 1'b0;
      end
   end

endmodule

// ===== design/b32kd_core.sv =====
// decode state and per-character result; state moves on advance
module b32kd_core import b32kd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    advance,
   input  req_type item,
   output rsp_type result
);

   logic [6:0] bit_buffer_ff, bit_buffer_in;
   logic [2:0] bit_count_ff, bit_count_in;
   logic [2:0] group_pos_ff, group_pos_in;
   logic       pad_seen_ff, pad_seen_in;
   logic [2:0] pad_count_ff, pad_count_in;
   logic [1:0] error_code_ff, error_code_in;

   logic [4:0]  sym_value;
   logic        sym_ok;
   logic        is_pad;
   logic [11:0] buf_wide;
   logic [3:0]  cnt_sum;
   logic [3:0]  cnt_left;
   logic        produce;
   logic [11:0] buf_shift;
   logic [7:0]  mask_wide;
   logic [1:0]  err;
   logic [1:0]  err_seq;
   logic        bits_taken;

   b32kd_sym u_sym (
      .in_char   (item.in_char),
      .sym_value (sym_value),
      .sym_ok    (sym_ok)
   );

   assign is_pad    = (item.in_char == PAD_CHAR);
   assign buf_wide  = {bit_buffer_ff, sym_value};
   assign cnt_sum   = {1'b0, bit_count_ff} + 4'd5;
   assign produce   = (cnt_sum >= 4'd8);
   assign cnt_left  = produce ? (cnt_sum - 4'd8) : cnt_sum;
   assign buf_shift = buf_wide >> cnt_left[2:0];
   assign mask_wide = (8'd1 << cnt_left[2:0]) - 8'd1;

   always_comb begin
      err        = STATUS_OK;
      bits_taken = 1'b0;
      pad_seen_in  = pad_seen_ff;
      pad_count_in = pad_count_ff;
      if (is_pad) begin
         // padding may only open at group position 2, 4, 5 or 7
         if (!pad_seen_ff) begin
            if (!(group_pos_ff == 3'd2 || group_pos_ff == 3'd4 ||
                  group_pos_ff == 3'd5 || group_pos_ff == 3'd7)) begin
               err = STATUS_BAD_PAD;
            end
            pad_seen_in = 1'b1;
         end
         if (pad_count_ff >= PAD_LIMIT) begin
            err = STATUS_BAD_PAD;
         end
         if (pad_count_ff != PAD_MAX) begin
            pad_count_in = pad_count_ff + 3'd1;
         end
      end else if (!sym_ok) begin
         err = STATUS_BAD_CHAR;
      end else if (pad_seen_ff) begin
         err = STATUS_BAD_PAD;
      end else begin
         bits_taken = 1'b1;
      end

      bit_count_in  = bits_taken ? cnt_left[2:0] : bit_count_ff;
      bit_buffer_in = bits_taken ? (buf_wide[6:0] & mask_wide[6:0]) : bit_buffer_ff;
      group_pos_in  = group_pos_ff + 3'd1;

      // first error wins; length checked only on the last character
      err_seq = (error_code_ff == STATUS_OK) ? err : error_code_ff;
      if (item.last && err_seq == STATUS_OK && group_pos_in != 3'd0) begin
         error_code_in = STATUS_BAD_LEN;
      end else begin
         error_code_in = err_seq;
      end

      result.byte_valid = bits_taken && produce && (error_code_in == STATUS_OK);
      result.out_byte   = result.byte_valid ? buf_shift[7:0] : 8'd0;
      result.done_res   = item.last;
      result.status     = error_code_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_buffer_ff <= '0;
         bit_count_ff  <= '0;
         group_pos_ff  <= '0;
         pad_seen_ff   <= 1'b0;
         pad_count_ff  <= '0;
         error_code_ff <= STATUS_OK;
      end else if (advance) begin
         if (item.last) begin
            bit_buffer_ff <= '0;
            bit_count_ff  <= '0;
            group_pos_ff  <= '0;
            pad_seen_ff   <= 1'b0;
            pad_count_ff  <= '0;
            error_code_ff <= STATUS_OK;
         end else begin
            bit_buffer_ff <= bit_buffer_in;
            bit_count_ff  <= bit_count_in;
            group_pos_ff  <= group_pos_in;
            pad_seen_ff   <= pad_seen_in;
            pad_count_ff  <= pad_count_in;
            error_code_ff <= error_code_in;
         end
      end
   end

endmodule

// ===== design/base32_key_decoder.sv =====
// base32_key_decoder: streaming base32 decoder, one character per word in,
// one result word out per character.
//
// req channel: valid/ready, req_data carries the character and a last flag
// marking the end of a string. rsp channel: valid/ready, rsp_data carries
// the decoded byte (with byte_valid), done_res for the last character and
// the sticky status (0 ok, 1 bad char, 2 bad padding, 3 bad length).
// Bytes of a string whose final status is not ok must be discarded.
//
// Each word passes the input register, then the result register (rsp_valid).
// Throughput: one word per cycle while rsp_ready is high; input register,
// lookup/regroup logic and result register form a single pass, and decode
// state updates as each word moves into the result register.
//
// Reset (synchronous, active high) empties both registers and clears all
// decode state. After a last word the decode state returns to its reset
// value, so the next word opens a new string.
// If the receiver stalls, the result register holds its word and the input
// register can still take one more word; req_ready drops only when both
// are full and rsp_ready is low.
module base32_key_decoder import b32kd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    s1_valid_ff, s1_valid_in;
   req_type s1_data_ff;
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type core_result;
   logic    advance;
   logic    req_fire;

   // input word moves on when the result register is free or draining
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   b32kd_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (s1_data_ff),
      .result  (core_result)
   );

   always_comb begin
      s1_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      rsp_valid_in = advance ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== design/b32kd_checker.sv =====
module b32kd_checker import b32kd_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a waiting input word holds
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid && $stable(req_data))
      else $error("req word changed while waiting");

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp word changed while stalled");

   // a byte is only sent while the string is still ok
   a_byte_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.byte_valid |-> rsp_data.status == STATUS_OK)
      else $error("byte sent with error status");

   a_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.byte_valid |-> rsp_data.out_byte == 8'd0)
      else $error("out_byte not zero without byte_valid");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

endmodule

bind base32_key_decoder b32kd_checker u_b32kd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== tb/sv/tb_top.sv =====
module tb_top;
   import b32kd_pkg::*;

   // run limits
   localparam int RANDOM_ITEMS = 1450;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   // window where neither side idles
   localparam int QUIET_START  = 600;
   localparam int QUIET_END    = 1400;

   // one character waiting to go out; hold means wait for all results first
   typedef struct {
      req_type word;
      bit      hold;
   } char_entry_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   char_entry_type char_queue[$];
   rsp_type   expected_rsp[$];
   logic      req_taken = 1'b0;
   int        cycle_count = 0;
   int        fail_count = 0;
   logic      quiet;

   // decoder state mirror: pending bits, group position, padding, sticky status
   logic [6:0] held_bits = '0;
   logic [2:0] held_count = '0;
   logic [2:0] group_pos = '0;
   logic       pad_started = 1'b0;
   logic [2:0] pad_total = '0;
   logic [1:0] sticky_status = STATUS_OK;

   base32_key_decoder u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   assign quiet = (cycle_count >= QUIET_START) && (cycle_count < QUIET_END);

   // Predict the result word for one character and advance the mirror state.
   function automatic rsp_type decode_char(req_type w);
      logic [4:0]  sym;
      logic        sym_ok;
      logic [1:0]  hit;
      logic [11:0] acc;
      logic [3:0]  nbits;
      logic [7:0]  byte_out;
      logic        made;
      rsp_type     r;
      sym = '0;
      sym_ok = 1'b1;
      hit = STATUS_OK;
      byte_out = '0;
      made = 1'b0;
      // alphabet lookup; '{' and everything outside the table is invalid
      if (w.in_char >= "A" && w.in_char <= "Z") sym = 5'(w.in_char - "A");
      else if (w.in_char >= "a" && w.in_char <= "z") sym = 5'(w.in_char - "a");
      else if (w.in_char >= "2" && w.in_char <= "7") sym = 5'(w.in_char - "2" + 8'd26);
      else if (w.in_char == "0") sym = 5'd14;
      else if (w.in_char == "1") sym = 5'd11;
      else if (w.in_char == "8") sym = 5'd1;
      else sym_ok = 1'b0;

      if (w.in_char == PAD_CHAR) begin
         // padding may only open at group positions 2, 4, 5 or 7
         if (!pad_started) begin
            if (!(group_pos inside {3'd2, 3'd4, 3'd5, 3'd7})) hit = STATUS_BAD_PAD;
            pad_started = 1'b1;
         end
         if (pad_total >= PAD_LIMIT) hit = STATUS_BAD_PAD;
         if (pad_total < PAD_MAX) pad_total = pad_total + 3'd1;
      end else if (!sym_ok) begin
         hit = STATUS_BAD_CHAR;
      end else if (pad_started) begin
         hit = STATUS_BAD_PAD;
      end else begin
         // append five bits MSB first, peel off a byte once eight are held
         acc = {held_bits, sym};
         nbits = {1'b0, held_count} + 4'd5;
         if (nbits >= 4'd8) begin
            nbits = nbits - 4'd8;
            byte_out = 8'(acc >> nbits);
            made = 1'b1;
         end
         held_count = nbits[2:0];
         held_bits = acc[6:0] & ((7'd1 << held_count) - 7'd1);
      end

      group_pos = group_pos + 3'd1;
      if (sticky_status == STATUS_OK && hit != STATUS_OK) sticky_status = hit;
      if (w.last && sticky_status == STATUS_OK && group_pos != 3'd0)
         sticky_status = STATUS_BAD_LEN;

      r.byte_valid = made && (sticky_status == STATUS_OK);
      r.out_byte = r.byte_valid ? byte_out : 8'd0;
      r.done_res = w.last;
      r.status = sticky_status;

      // a last character closes the string
      if (w.last) begin
         held_bits = '0;
         held_count = '0;
         group_pos = '0;
         pad_started = 1'b0;
         pad_total = '0;
         sticky_status = STATUS_OK;
      end
      return r;
   endfunction

   task automatic check_field(string fname, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", fname, want, got);
         fail_count++;
      end
   endtask

   // random alphabet character: upper, lower, digits and the aliases
   function automatic logic [7:0] rand_symbol_char();
      int unsigned k;
      k = $urandom_range(0, 60);
      if (k < 26) return 8'(8'h41 + k);
      if (k < 52) return 8'(8'h61 + k - 26);
      if (k < 58) return 8'(8'h32 + k - 52);
      if (k == 58) return "0";
      if (k == 59) return "1";
      return "8";
   endfunction

   // queue one string; last goes on its final character
   task automatic add_bytes(logic [7:0] s[$], bit hold_first);
      char_entry_type e;
      for (int i = 0; i < s.size(); i++) begin
         e.word.in_char = s[i];
         e.word.last = (i == s.size() - 1);
         e.hold = hold_first && (i == 0);
         char_queue.push_back(e);
      end
   endtask

   task automatic add_text(string t);
      logic [7:0] s[$];
      for (int i = 0; i < t.len(); i++) s.push_back(t[i]);
      add_bytes(s, 1'b0);
   endtask

   // Mostly well-formed strings with random content and optional padding,
   // the rest broken in one way or another, or plain noise.
   task automatic add_random_string(bit hold_first);
      logic [7:0]  s[$];
      int unsigned ngroups;
      int unsigned npad;
      int unsigned mode;
      int unsigned idx;
      int unsigned len;
      ngroups = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 9) : $urandom_range(1, 3);
      for (int i = 0; i < ngroups * 8; i++) s.push_back(rand_symbol_char());
      if ($urandom_range(0, 1)) begin
         case ($urandom_range(0, 3))
            0: npad = 6;
            1: npad = 4;
            2: npad = 3;
            default: npad = 1;
         endcase
         for (int i = 0; i < npad; i++) s[s.size() - 1 - i] = PAD_CHAR;
      end
      mode = $urandom_range(0, 99);
      if (mode < 70) begin
         // well-formed as built
      end else if (mode < 76) begin
         // any byte somewhere
         idx = $urandom_range(0, s.size() - 1);
         s[idx] = 8'($urandom_range(0, 255));
      end else if (mode < 82) begin
         // one character short or long
         idx = $urandom_range(0, s.size() - 1);
         if ($urandom_range(0, 1)) s.delete(idx);
         else s.insert(idx, $urandom_range(0, 3) == 0 ? PAD_CHAR : rand_symbol_char());
      end else if (mode < 87) begin
         // padding opening at a forbidden position, running to the end
         case ($urandom_range(0, 3))
            0: idx = 0;
            1: idx = 1;
            2: idx = 3;
            default: idx = 6;
         endcase
         idx = idx + 8 * $urandom_range(0, ngroups - 1);
         for (int i = int'(idx); i < s.size(); i++) s[i] = PAD_CHAR;
      end else if (mode < 91) begin
         // symbol after padding
         for (int i = s.size() - 6; i < s.size() - 1; i++) s[i] = PAD_CHAR;
         s[s.size() - 1] = rand_symbol_char();
      end else if (mode < 95) begin
         // nine pads in a row, opening legally at position 7
         if (s.size() >= 16)
            for (int i = s.size() - 9; i < s.size(); i++) s[i] = PAD_CHAR;
      end else begin
         // noise: short string of raw bytes, symbols and pads
         len = $urandom_range(1, 12);
         s.delete();
         for (int i = 0; i < len; i++) begin
            case ($urandom_range(0, 2))
               0: s.push_back(8'($urandom_range(0, 255)));
               1: s.push_back(PAD_CHAR);
               default: s.push_back(rand_symbol_char());
            endcase
         end
      end
      add_bytes(s, hold_first);
   endtask

   // Monitor: predict on each accepted input word, check each accepted
   // result word against the oldest prediction.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else if (!reset) begin
         req_taken <= req_valid && req_ready;
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp.size() == 0) begin
               $error("unexpected result word %0h", rsp_data);
               fail_count++;
            end else begin
               check_field("out_byte", expected_rsp[0].out_byte, rsp_data.out_byte);
               check_field("byte_valid", 8'(expected_rsp[0].byte_valid),
                           8'(rsp_data.byte_valid));
               check_field("done_res", 8'(expected_rsp[0].done_res),
                           8'(rsp_data.done_res));
               check_field("status", 8'(expected_rsp[0].status), 8'(rsp_data.status));
               void'(expected_rsp.pop_front());
            end
         end
         if (req_valid && req_ready) expected_rsp.push_back(decode_char(req_data));
      end
   end

   // Driver: inputs move on the falling edge. Valid holds until the word
   // is taken; each side idles about one cycle in ten outside the quiet window.
   always @(negedge clock) begin
      if (!reset) begin
         rsp_ready <= quiet || ($urandom_range(0, 99) >= 10);
         if (!req_valid || req_taken) begin
            if (char_queue.size() != 0 && (quiet || $urandom_range(0, 99) >= 10)
                && !(char_queue[0].hold && expected_rsp.size() != 0)) begin
               req_data <= char_queue[0].word;
               req_valid <= 1'b1;
               void'(char_queue.pop_front());
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   initial begin
      int random_items;
      // directed: full valid group with extremes and aliases, padding at
      // position 2 with six pads, '{', padding at position 0, a lone
      // character (bad length), a symbol after padding
      add_text("Az7a0218");
      add_text("MY======");
      add_text("{");
      add_text("=");
      add_text("Z");
      add_text("AB=C");

      random_items = 0;
      while (random_items < RANDOM_ITEMS) begin
         // the first random string and a few more wait for a drained pipe
         add_random_string(random_items == 0 || $urandom_range(0, 19) == 0);
         random_items = char_queue.size();
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (char_queue.size() != 0 || req_valid) @(posedge clock);
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
